### src/mpse_pkg.sv
// Shared types, constants and helpers for the matrix product-sum engine.
// No dependencies; every other file but mpse_ram imports this package.
package mpse_pkg;

	localparam int MAX_DIM = 16;
	localparam int ELEMENT_WIDTH = 16;
	localparam int VALUE_W = 16;
	localparam int IDX_W = 4;
	localparam int SIZE_W = 5;
	localparam int RES_W = 40;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = 2 * ELEMENT_WIDTH;
	localparam int NUM_MAT = 4;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		MAT_A = 2'd0,
		MAT_B = 2'd1,
		MAT_C = 2'd2,
		MAT_D = 2'd3
	} mat_sel_t;

	typedef struct packed {
		action_t action;
		mat_sel_t matrix_select;
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic signed [VALUE_W-1:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic index_error;
	} out_item_t;

	typedef struct packed {
		logic [NUM_MAT-1:0] we;
		logic [ADDR_W-1:0] addr;
		logic signed [ELEMENT_WIDTH-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] row_addr;
		logic [ADDR_W-1:0] col_addr;
	} mem_rd_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic clear;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
		logic signed [RES_W-1:0] acc;
	} mac_stat_t;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [SIZE_W-1:0] r,
			input logic [SIZE_W-1:0] c);
		return ADDR_W'(int'(r) * MAX_DIM + int'(c));
	endfunction

endpackage

### src/matrix_product_sum_engine.sv
// Matrix product-sum engine: holds matrices A, B, C, D and returns elements of
// A*A + A*B + C*D. A load is written into its RAM when accepted. A query with
// matrix_size n walks the inner index one step per cycle through the element RAMs
// (one read port each, A kept in two copies for row and column reads), then goes
// through the RAM read, product and accumulate stages and the result register.
// Out-of-range queries skip the walk and return index_error. One item is in work at
// a time; a result waiting in the output register does not block loads or the start
// of the next query. Depends on mpse_pkg, mpse_ram, mpse_mac, mpse_seq.
module matrix_product_sum_engine import mpse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [SIZE_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] size_q;
	mem_wr_t wr;
	mem_rd_t rd;
	mac_ctl_t ctl;
	mac_stat_t stat;
	logic signed [ELEMENT_WIDTH-1:0] a_row, a_col, b_col, c_row, d_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	mpse_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_a_row (
		.clk(clk), .we(wr.we[MAT_A]), .waddr(wr.addr), .wdata(wr.data),
		.raddr(rd.row_addr), .rdata(a_row)
	);

	mpse_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_a_col (
		.clk(clk), .we(wr.we[MAT_A]), .waddr(wr.addr), .wdata(wr.data),
		.raddr(rd.col_addr), .rdata(a_col)
	);

	mpse_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_b (
		.clk(clk), .we(wr.we[MAT_B]), .waddr(wr.addr), .wdata(wr.data),
		.raddr(rd.col_addr), .rdata(b_col)
	);

	mpse_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_c (
		.clk(clk), .we(wr.we[MAT_C]), .waddr(wr.addr), .wdata(wr.data),
		.raddr(rd.row_addr), .rdata(c_row)
	);

	mpse_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram_d (
		.clk(clk), .we(wr.we[MAT_D]), .waddr(wr.addr), .wdata(wr.data),
		.raddr(rd.col_addr), .rdata(d_col)
	);

	mpse_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.a_row(a_row), .a_col(a_col), .b_col(b_col), .c_row(c_row), .d_col(d_col),
		.stat(stat)
	);

	mpse_seq u_seq (
		.clk(clk), .arst_n(arst_n), .size_q(size_q),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.wr(wr), .rd(rd), .ctl(ctl), .stat(stat)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.index_error |-> result.result_value == '0)
		else $error("error result carries nonzero value");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> item_stall)
		else $error("accumulation finished while sequencer idle");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a query in work");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr.we) && (wr.we == '0 || !item_stall))
		else $error("RAM write outside an accepted load");

endmodule

### src/mpse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mpse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/mpse_mac.sv
// Three-lane multiply-accumulate pipeline: product stage, then 40-bit accumulator.
// Depends on mpse_pkg.
module mpse_mac import mpse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mac_ctl_t ctl,
	input logic signed [ELEMENT_WIDTH-1:0] a_row,
	input logic signed [ELEMENT_WIDTH-1:0] a_col,
	input logic signed [ELEMENT_WIDTH-1:0] b_col,
	input logic signed [ELEMENT_WIDTH-1:0] c_row,
	input logic signed [ELEMENT_WIDTH-1:0] d_col,
	output mac_stat_t stat
);

	logic signed [PROD_W-1:0] p_aa_s2, p_ab_s2, p_cd_s2;
	logic prod_v_s2, last_s2, done_q;
	logic signed [RES_W-1:0] acc_q, acc_next;

	always_ff @(posedge clk) begin
		p_aa_s2 <= a_row * a_col;
		p_ab_s2 <= a_row * b_col;
		p_cd_s2 <= c_row * d_col;
	end

	always_comb begin
		acc_next = acc_q + RES_W'(p_aa_s2) + RES_W'(p_ab_s2) + RES_W'(p_cd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			done_q <= 1'b0;
			acc_q <= '0;
		end else begin
			prod_v_s2 <= ctl.valid;
			last_s2 <= ctl.valid & ctl.last;
			done_q <= prod_v_s2 & last_s2;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (prod_v_s2) begin
				acc_q <= acc_next;
			end
		end
	end

	assign stat = '{done: done_q, acc: acc_q};

endmodule

### src/mpse_seq.sv
// Transaction sequencer: load writes, inner-index walk for queries, result register.
// Depends on mpse_pkg.
module mpse_seq import mpse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [SIZE_W-1:0] size_q,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result,
	output mem_wr_t wr,
	output mem_rd_t rd,
	output mac_ctl_t ctl,
	input mac_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [SIZE_W-1:0] n, row_ext, col_ext, row_q, col_q, k_q;
	logic accept, in_range, in_store, is_last;
	logic v_s1, last_s1, clear_s1;
	logic signed [RES_W-1:0] res_q;
	logic err_q, out_valid_q;
	out_item_t out_q;

	always_comb begin
		n = (int'(size_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_q;
		item_stall = (state_q != ST_IDLE);
		accept = item_valid && (state_q == ST_IDLE);
		row_ext = SIZE_W'(item.row_index);
		col_ext = SIZE_W'(item.col_index);
		in_range = (row_ext < n) && (col_ext < n);
		in_store = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
		is_last = (k_q == n - SIZE_W'(1));
		wr.we = '0;
		if (accept && item.action == ACT_LOAD && in_store) begin
			wr.we[item.matrix_select] = 1'b1;
		end
		wr.addr = elem_addr(row_ext, col_ext);
		wr.data = ELEMENT_WIDTH'(item.element_value);
		rd.row_addr = elem_addr(row_q, k_q);
		rd.col_addr = elem_addr(k_q, col_q);
		ctl = '{valid: v_s1, last: last_s1, clear: clear_s1};
		result_valid = out_valid_q;
		result = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			clear_s1 <= 1'b0;
			res_q <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && is_last;
			clear_s1 <= accept && (item.action == ACT_QUERY) && in_range;
			if (state_q == ST_DONE && (!out_valid_q || !result_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.action == ACT_QUERY) begin
						row_q <= row_ext;
						col_q <= col_ext;
						k_q <= '0;
						if (in_range) begin
							state_q <= ST_RUN;
						end else begin
							res_q <= '0;
							err_q <= 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + SIZE_W'(1);
					if (is_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (stat.done) begin
						res_q <= stat.acc;
						err_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !result_stall) begin
						out_q <= '{result_value: res_q, index_error: err_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
